// ===== src/epipolar_line_from_point_assert.svh =====
// assertion macros shared by the epipolar line block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef EPIPOLAR_LINE_FROM_POINT_ASSERT_SVH
`define EPIPOLAR_LINE_FROM_POINT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ELFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ELFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/elfp_pkg.sv =====
// types, widths and register codes of the epipolar line block
// no dependencies
package elfp_pkg;

    localparam int COORD_BITS = 16;
    localparam int COEF_BITS  = 48;
    localparam int COEF_FRAC  = 32;
    localparam int COORD_FRAC = 4;
    localparam int AB_FRAC    = 30;
    localparam int AB_BITS    = 32;
    localparam int C_OUT_BITS = 48;

    // apb port
    localparam int NUM_REGS = 8;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = $clog2(NUM_REGS * 8);
    localparam int IDX_W    = $clog2(NUM_REGS);

    // raw line terms
    localparam int TERM_W = COEF_BITS + COORD_BITS + 1;
    localparam int V_W    = TERM_W + 2;

    // normalize datapath
    localparam int SC_W   = 31;
    localparam int RT_W   = 32;
    localparam int S_W    = $clog2(V_W + 1);
    localparam int S_MAX  = V_W - SC_W;
    localparam int D_W    = RT_W + S_MAX;
    localparam int NC_W   = V_W + AB_FRAC + 1;
    localparam int NAB_W  = SC_W + AB_FRAC + 1;
    localparam int QC_W   = C_OUT_BITS + 1;
    localparam int AB_Q   = SC_W;

    // queue depths
    localparam int Q1_DEPTH_DEF = 8;
    localparam int Q2_DEPTH_DEF = 128;

    typedef enum logic [IDX_W-1:0] {
        REG_F11 = 3'd0,
        REG_F12 = 3'd1,
        REG_F13 = 3'd2,
        REG_F21 = 3'd3,
        REG_F22 = 3'd4,
        REG_F23 = 3'd5,
        REG_F31 = 3'd6,
        REG_F32 = 3'd7
    } t_reg_idx;

    typedef logic [COEF_BITS-1:0] t_coef;

    typedef struct packed {
        t_coef f11;
        t_coef f12;
        t_coef f13;
        t_coef f21;
        t_coef f22;
        t_coef f23;
        t_coef f31;
        t_coef f32;
    } t_fmat;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  use_transpose;
    } t_point;

    typedef struct packed {
        logic signed [AB_BITS-1:0]    line_a;
        logic signed [AB_BITS-1:0]    line_b;
        logic signed [C_OUT_BITS-1:0] line_c;
        logic                         degenerate;
    } t_line;

    typedef struct packed {
        logic signed [V_W-1:0] a;
        logic signed [V_W-1:0] b;
        logic signed [V_W-1:0] c;
    } t_abc;

endpackage

// ===== src/elfp_regs.sv =====
// matrix coefficient registers behind the apb port
// depends on elfp_pkg
module elfp_regs import elfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_fmat             o_fm
);

    t_fmat    r_fm;
    t_reg_idx idx;
    logic     wr;
    t_coef    rd_val;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_F11: r_fm.f11 <= pwdata[COEF_BITS-1:0];
                REG_F12: r_fm.f12 <= pwdata[COEF_BITS-1:0];
                REG_F13: r_fm.f13 <= pwdata[COEF_BITS-1:0];
                REG_F21: r_fm.f21 <= pwdata[COEF_BITS-1:0];
                REG_F22: r_fm.f22 <= pwdata[COEF_BITS-1:0];
                REG_F23: r_fm.f23 <= pwdata[COEF_BITS-1:0];
                REG_F31: r_fm.f31 <= pwdata[COEF_BITS-1:0];
                REG_F32: r_fm.f32 <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_F11: rd_val = r_fm.f11;
            REG_F12: rd_val = r_fm.f12;
            REG_F13: rd_val = r_fm.f13;
            REG_F21: rd_val = r_fm.f21;
            REG_F22: rd_val = r_fm.f22;
            REG_F23: rd_val = r_fm.f23;
            REG_F31: rd_val = r_fm.f31;
            REG_F32: rd_val = r_fm.f32;
            default: rd_val = '0;
        endcase
    end

    assign prdata = APB_DW'(rd_val);
    assign o_fm   = r_fm;

endmodule

// ===== src/elfp_front.sv =====
// front part: takes points and forms the raw line terms F p or F^T p
// depends on elfp_pkg
module elfp_front import elfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_point i_pt,
    input  t_fmat  i_fm,
    output logic   o_vld,
    output t_abc   o_abc
);

    localparam int LO_W = COEF_BITS / 2;
    localparam int HI_W = COEF_BITS - LO_W;
    localparam int PL_W = LO_W + COORD_BITS;
    localparam int PH_W = HI_W + COORD_BITS + 1;
    localparam logic signed [TERM_W-1:0] F33_TERM =
        TERM_W'(1) <<< (COEF_FRAC + COORD_FRAC);

    // stage 0: accepted point
    logic   r0_vld;
    t_point r0_pt;

    // stage 1: split products
    logic                   r1_vld;
    logic [PL_W-1:0]        r1_plo [3][2];
    logic signed [PH_W-1:0] r1_phi [3][2];
    t_coef                  r1_cz  [2];

    // stage 2: full terms
    logic                     r2_vld;
    logic signed [TERM_W-1:0] r2_t [3][3];

    // stage 3: line terms
    logic r3_vld;
    t_abc r3_abc;

    t_coef                  m [9];
    t_coef                  csel [3][3];
    logic [PL_W-1:0]        n_plo [3][2];
    logic signed [PH_W-1:0] n_phi [3][2];
    logic [COORD_BITS-1:0]  crd [2];

    always_comb begin
        m[0] = i_fm.f11; m[1] = i_fm.f12; m[2] = i_fm.f13;
        m[3] = i_fm.f21; m[4] = i_fm.f22; m[5] = i_fm.f23;
        m[6] = i_fm.f31; m[7] = i_fm.f32; m[8] = '0;
        crd[0] = r0_pt.point_x;
        crd[1] = r0_pt.point_y;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                csel[r][k] = r0_pt.use_transpose ? m[k*3+r] : m[r*3+k];
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 2; k++) begin
                n_plo[r][k] = PL_W'(csel[r][k][LO_W-1:0]) * PL_W'(crd[k]);
                n_phi[r][k] = PH_W'($signed(csel[r][k][COEF_BITS-1:LO_W]))
                              * $signed(PH_W'(crd[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r0_vld <= i_take;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_pt <= i_pt;
        r1_plo <= n_plo;
        r1_phi <= n_phi;
        r1_cz[0] <= csel[0][2];
        r1_cz[1] <= csel[1][2];
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 2; k++) begin
                r2_t[r][k] <= (TERM_W'(r1_phi[r][k]) <<< LO_W)
                              + TERM_W'($signed({1'b0, r1_plo[r][k]}));
            end
        end
        // homogeneous 1 is 16 in q.4; f33 is exactly 1
        r2_t[0][2] <= TERM_W'($signed(r1_cz[0])) <<< COORD_FRAC;
        r2_t[1][2] <= TERM_W'($signed(r1_cz[1])) <<< COORD_FRAC;
        r2_t[2][2] <= F33_TERM;
        r3_abc.a <= V_W'(r2_t[0][0]) + V_W'(r2_t[0][1]) + V_W'(r2_t[0][2]);
        r3_abc.b <= V_W'(r2_t[1][0]) + V_W'(r2_t[1][1]) + V_W'(r2_t[1][2]);
        r3_abc.c <= V_W'(r2_t[2][0]) + V_W'(r2_t[2][1]) + V_W'(r2_t[2][2]);
    end

    assign o_vld = r3_vld;
    assign o_abc = r3_abc;

endmodule

// ===== src/elfp_fifo.sv =====
// queue with slot claims and a registered head, used between front and back and as the output queue
// depends on elfp_pkg and the assertion macro header
module elfp_fifo import elfp_pkg::*; #(
    parameter int DEPTH = Q1_DEPTH_DEF,
    parameter int W     = V_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_claim,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    input  logic         i_rd,
    output logic         o_valid,
    output logic [W-1:0] o_rdata,
    output logic         o_room
);

`include "epipolar_line_from_point_assert.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_mcnt, r_res;
    logic             r_ovld;
    logic [W-1:0]     r_dout;
    logic             pop, load;

    assign pop  = i_rd && r_ovld;
    assign load = (r_mcnt != '0) && (!r_ovld || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_mcnt <= '0;
            r_res  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (load) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            r_mcnt <= r_mcnt + CNT_W'(i_wr) - CNT_W'(load);
            r_res  <= r_res + CNT_W'(i_claim) - CNT_W'(pop);
            if (load) begin
                r_ovld <= 1'b1;
            end else if (pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
        if (load) begin
            r_dout <= r_mem[r_rp];
        end
    end

    assign o_valid = r_ovld;
    assign o_rdata = r_dout;
    assign o_room  = r_res < CNT_W'(DEPTH);

    `ELFP_ASSERT_IMP(a_no_overrun, i_wr, r_mcnt < CNT_W'(DEPTH), "write into full queue")
    `ELFP_ASSERT_IMP(a_claims_cover, 1'b1, r_res >= r_mcnt + CNT_W'(r_ovld), "item without claim")
    `ELFP_ASSERT_IMP(a_pop_valid, i_rd, r_ovld, "pop of empty head")
    `ELFP_ASSERT_NXT(a_drain, pop && (r_mcnt == '0), !r_ovld, "head kept after last pop")

endmodule

// ===== src/elfp_back.sv =====
// back part: scales, takes the root and divides the line terms
// depends on elfp_pkg
module elfp_back import elfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q1_valid,
    input  t_abc  i_abc,
    input  logic  i_room,
    output logic  o_take,
    output logic  o_vld,
    output t_line o_line
);

    typedef struct packed {
        logic [SC_W-1:0] sa;
        logic [SC_W-1:0] sb;
        logic [V_W-1:0]  mc;
        logic [S_W-1:0]  s;
        logic            na;
        logic            nb;
        logic            nc;
        logic            dg;
    } t_carry;

    localparam logic [QC_W-1:0] C_POS_LIM = (QC_W'(1) << (C_OUT_BITS - 1)) - QC_W'(1);
    localparam logic [QC_W-1:0] C_NEG_LIM = QC_W'(1) << (C_OUT_BITS - 1);

    function automatic logic [S_W-1:0] bit_len(input logic [V_W-1:0] x);
        logic [S_W-1:0] n;
        n = '0;
        for (int i = 0; i < V_W; i++) begin
            if (x[i]) n = S_W'(i + 1);
        end
        return n;
    endfunction

    // b1 magnitudes
    logic           r1_vld;
    logic [V_W-1:0] r1_ma, r1_mb, r1_mc, r1_or;
    logic           r1_na, r1_nb, r1_nc;
    // b2 scale shift
    logic           r2_vld;
    logic [V_W-1:0] r2_ma, r2_mb, r2_mc;
    logic [S_W-1:0] r2_s;
    logic           r2_na, r2_nb, r2_nc, r2_dg;
    // b3 scaled values
    logic   r3_vld;
    t_carry r3_c;
    // b4 squares
    logic              r4_vld;
    t_carry            r4_c;
    logic [2*SC_W-1:0] r4_qa, r4_qb;
    // sqrt stages
    logic              r_sq_vld  [RT_W+1];
    t_carry            r_sq_c    [RT_W+1];
    logic [2*RT_W-1:0] r_sq_v    [RT_W+1];
    logic [RT_W+1:0]   r_sq_rem  [RT_W+1];
    logic [RT_W-1:0]   r_sq_root [RT_W+1];
    // divide setup
    logic             r6_vld;
    t_carry           r6_c;
    logic [RT_W-1:0]  r6_rt;
    logic [D_W-1:0]   r6_d;
    logic [NC_W-1:0]  r6_nc;
    logic [NAB_W-1:0] r6_na, r6_nb;
    // divide stages
    logic            r_dv_vld [QC_W+1];
    logic [3:0]      r_dv_fl  [QC_W+1];
    logic            r_dv_ovf [QC_W+1];
    logic [D_W-1:0]  r_dv_d   [QC_W+1];
    logic [D_W-1:0]  r_dv_rc  [QC_W+1];
    logic [QC_W-1:0] r_dv_nc  [QC_W+1];
    logic [QC_W-1:0] r_dv_qc  [QC_W+1];
    logic [RT_W-1:0] r_dv_rt  [QC_W+1];
    logic [RT_W-1:0] r_dv_ra  [QC_W+1];
    logic [RT_W-1:0] r_dv_rb  [QC_W+1];
    logic [AB_Q-1:0] r_dv_la  [QC_W+1];
    logic [AB_Q-1:0] r_dv_lb  [QC_W+1];
    logic [AB_Q-1:0] r_dv_qa  [QC_W+1];
    logic [AB_Q-1:0] r_dv_qb  [QC_W+1];
    // result
    logic  r_out_vld;
    t_line r_out;

    logic [S_W-1:0] n_bl;

    assign o_take = i_q1_valid && i_room;
    assign n_bl   = bit_len(r1_or);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r6_vld <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r1_vld <= o_take;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_sq_vld[0] <= r4_vld;
            r6_vld <= r_sq_vld[RT_W];
            r_dv_vld[0] <= r6_vld;
            r_out_vld <= r_dv_vld[QC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_na <= i_abc.a[V_W-1];
        r1_nb <= i_abc.b[V_W-1];
        r1_nc <= i_abc.c[V_W-1];
        r1_ma <= i_abc.a[V_W-1] ? V_W'(-i_abc.a) : V_W'(i_abc.a);
        r1_mb <= i_abc.b[V_W-1] ? V_W'(-i_abc.b) : V_W'(i_abc.b);
        r1_mc <= i_abc.c[V_W-1] ? V_W'(-i_abc.c) : V_W'(i_abc.c);
        r1_or <= (i_abc.a[V_W-1] ? V_W'(-i_abc.a) : V_W'(i_abc.a))
               | (i_abc.b[V_W-1] ? V_W'(-i_abc.b) : V_W'(i_abc.b));

        // bit length of max(|a|,|b|) equals that of their or
        r2_ma <= r1_ma;
        r2_mb <= r1_mb;
        r2_mc <= r1_mc;
        r2_na <= r1_na;
        r2_nb <= r1_nb;
        r2_nc <= r1_nc;
        r2_dg <= (r1_or == '0);
        r2_s  <= (n_bl > S_W'(SC_W)) ? n_bl - S_W'(SC_W) : '0;

        r3_c.sa <= SC_W'(r2_ma >> r2_s);
        r3_c.sb <= SC_W'(r2_mb >> r2_s);
        r3_c.mc <= r2_mc;
        r3_c.s  <= r2_s;
        r3_c.na <= r2_na;
        r3_c.nb <= r2_nb;
        r3_c.nc <= r2_nc;
        r3_c.dg <= r2_dg;

        r4_c  <= r3_c;
        r4_qa <= (2*SC_W)'(r3_c.sa) * (2*SC_W)'(r3_c.sa);
        r4_qb <= (2*SC_W)'(r3_c.sb) * (2*SC_W)'(r3_c.sb);

        r_sq_c[0]    <= r4_c;
        r_sq_v[0]    <= (2*RT_W)'(r4_qa) + (2*RT_W)'(r4_qb);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    // integer square root, two radicand bits per stage
    for (genvar i = 0; i < RT_W; i++) begin : g_sqrt
        logic [RT_W+1:0] rem_sh, trial;
        logic            ge;
        assign rem_sh = {r_sq_rem[i][RT_W-1:0], r_sq_v[i][2*(RT_W-1-i) +: 2]};
        assign trial  = {r_sq_root[i], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[i+1] <= 1'b0;
            end else begin
                r_sq_vld[i+1] <= r_sq_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_c[i+1]    <= r_sq_c[i];
            r_sq_v[i+1]    <= r_sq_v[i];
            r_sq_rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
            r_sq_root[i+1] <= {r_sq_root[i][RT_W-2:0], ge};
        end
    end

    logic [D_W-1:0] n_d;
    assign n_d = D_W'(r_sq_root[RT_W]) << r_sq_c[RT_W].s;

    always_ff @(posedge i_clk) begin
        r6_c  <= r_sq_c[RT_W];
        r6_rt <= r_sq_root[RT_W];
        r6_d  <= n_d;
        r6_na <= (NAB_W'(r_sq_c[RT_W].sa) << AB_FRAC) + NAB_W'(r_sq_root[RT_W] >> 1);
        r6_nb <= (NAB_W'(r_sq_c[RT_W].sb) << AB_FRAC) + NAB_W'(r_sq_root[RT_W] >> 1);
        r6_nc <= (NC_W'(r_sq_c[RT_W].mc) << AB_FRAC) + NC_W'(n_d >> 1);

        // upper numerator bits seed the remainders; c overflows past qc_w bits
        r_dv_fl[0]  <= {r6_c.na, r6_c.nb, r6_c.nc, r6_c.dg};
        r_dv_ovf[0] <= D_W'(r6_nc >> QC_W) >= r6_d;
        r_dv_d[0]   <= r6_d;
        r_dv_rc[0]  <= D_W'(r6_nc >> QC_W);
        r_dv_nc[0]  <= r6_nc[QC_W-1:0];
        r_dv_qc[0]  <= '0;
        r_dv_rt[0]  <= r6_rt;
        r_dv_ra[0]  <= RT_W'(r6_na >> AB_Q);
        r_dv_rb[0]  <= RT_W'(r6_nb >> AB_Q);
        r_dv_la[0]  <= r6_na[AB_Q-1:0];
        r_dv_lb[0]  <= r6_nb[AB_Q-1:0];
        r_dv_qa[0]  <= '0;
        r_dv_qb[0]  <= '0;
    end

    // restoring division, one quotient bit per stage; a and b run in the last stages
    for (genvar k = 0; k < QC_W; k++) begin : g_div
        logic [D_W:0]  tc;
        logic          gc;
        logic [RT_W:0] ta, tb;
        logic          ga, gb;
        assign tc = {r_dv_rc[k], r_dv_nc[k][QC_W-1]};
        assign gc = tc >= {1'b0, r_dv_d[k]};
        assign ta = {r_dv_ra[k], r_dv_la[k][AB_Q-1]};
        assign tb = {r_dv_rb[k], r_dv_lb[k][AB_Q-1]};
        assign ga = ta >= {1'b0, r_dv_rt[k]};
        assign gb = tb >= {1'b0, r_dv_rt[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_fl[k+1]  <= r_dv_fl[k];
            r_dv_ovf[k+1] <= r_dv_ovf[k];
            r_dv_d[k+1]   <= r_dv_d[k];
            r_dv_rt[k+1]  <= r_dv_rt[k];
            r_dv_rc[k+1]  <= gc ? D_W'(tc - {1'b0, r_dv_d[k]}) : D_W'(tc);
            r_dv_nc[k+1]  <= r_dv_nc[k] << 1;
            r_dv_qc[k+1]  <= {r_dv_qc[k][QC_W-2:0], gc};
            if (k >= QC_W - AB_Q) begin
                r_dv_ra[k+1] <= ga ? RT_W'(ta - {1'b0, r_dv_rt[k]}) : RT_W'(ta);
                r_dv_rb[k+1] <= gb ? RT_W'(tb - {1'b0, r_dv_rt[k]}) : RT_W'(tb);
                r_dv_la[k+1] <= r_dv_la[k] << 1;
                r_dv_lb[k+1] <= r_dv_lb[k] << 1;
                r_dv_qa[k+1] <= {r_dv_qa[k][AB_Q-2:0], ga};
                r_dv_qb[k+1] <= {r_dv_qb[k][AB_Q-2:0], gb};
            end else begin
                r_dv_ra[k+1] <= r_dv_ra[k];
                r_dv_rb[k+1] <= r_dv_rb[k];
                r_dv_la[k+1] <= r_dv_la[k];
                r_dv_lb[k+1] <= r_dv_lb[k];
                r_dv_qa[k+1] <= r_dv_qa[k];
                r_dv_qb[k+1] <= r_dv_qb[k];
            end
        end
    end

    logic            f_na, f_nb, f_nc, f_dg;
    logic [QC_W-1:0] lim, qcs;
    logic [AB_BITS-1:0] qa_w, qb_w;

    always_comb begin
        {f_na, f_nb, f_nc, f_dg} = r_dv_fl[QC_W];
        lim  = f_nc ? C_NEG_LIM : C_POS_LIM;
        qcs  = (r_dv_ovf[QC_W] || (r_dv_qc[QC_W] > lim)) ? lim : r_dv_qc[QC_W];
        qa_w = AB_BITS'(r_dv_qa[QC_W]);
        qb_w = AB_BITS'(r_dv_qb[QC_W]);
    end

    always_ff @(posedge i_clk) begin
        if (f_dg) begin
            r_out.line_a <= '0;
            r_out.line_b <= '0;
            r_out.line_c <= '0;
        end else begin
            r_out.line_a <= f_na ? -qa_w : qa_w;
            r_out.line_b <= f_nb ? -qb_w : qb_w;
            r_out.line_c <= f_nc ? C_OUT_BITS'(-qcs) : C_OUT_BITS'(qcs);
        end
        r_out.degenerate <= f_dg;
    end

    assign o_vld  = r_out_vld;
    assign o_line = r_out;

endmodule

// ===== src/epipolar_line_from_point.sv =====
// top level of the epipolar line block: registers, front, queues, back
// depends on elfp_pkg, elfp_regs, elfp_front, elfp_fifo, elfp_back
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in  (t_point)
//  output    out        o_out_valid / i_out_stall   o_out (t_line)
//  config    in         apb psel/penable/pready     pwdata, 64 bits, 8*i
//
// one point per cycle sustained while no stall holds the flow; from an input accept
// to the earliest output accept an item passes 4 front stages, the front queue, the
// back part (mostly the 32-stage root and the 49-stage divider) and the output queue
// reset is synchronous and clears only control state; coefficients reset to 0
// input stalls once the front queue has all its slots claimed
// output stall is absorbed by the output queue, whose claims hold the back part
module epipolar_line_from_point import elfp_pkg::*; #(
    parameter int Q1_DEPTH = Q1_DEPTH_DEF,
    parameter int Q2_DEPTH = Q2_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_point            i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_line             o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_fmat fm;
    logic  in_take;
    logic  q1_room, q2_room;
    logic  fr_vld, q1_valid, bk_take, bk_vld;
    t_abc  fr_abc, q1_abc;
    t_line bk_line;
    logic [$bits(t_abc)-1:0]  q1_rdata;
    logic [$bits(t_line)-1:0] q2_rdata;

    // an item claims a front queue slot as it enters
    assign in_take    = i_in_valid && q1_room;
    assign o_in_stall = !q1_room;

    elfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_fm    (fm)
    );

    elfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_pt    (i_in),
        .i_fm    (fm),
        .o_vld   (fr_vld),
        .o_abc   (fr_abc)
    );

    // queue between front and back
    elfp_fifo #(
        .DEPTH (Q1_DEPTH),
        .W     ($bits(t_abc))
    ) u_q1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_claim (in_take),
        .i_wr    (fr_vld),
        .i_wdata (fr_abc),
        .i_rd    (bk_take),
        .o_valid (q1_valid),
        .o_rdata (q1_rdata),
        .o_room  (q1_room)
    );

    assign q1_abc = t_abc'(q1_rdata);

    // back takes an item only with an output slot claimed for it
    elfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q1_valid (q1_valid),
        .i_abc      (q1_abc),
        .i_room     (q2_room),
        .o_take     (bk_take),
        .o_vld      (bk_vld),
        .o_line     (bk_line)
    );

    // output queue, its head register drives the result port
    elfp_fifo #(
        .DEPTH (Q2_DEPTH),
        .W     ($bits(t_line))
    ) u_q2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_claim (bk_take),
        .i_wr    (bk_vld),
        .i_wdata (bk_line),
        .i_rd    (o_out_valid && !i_out_stall),
        .o_valid (o_out_valid),
        .o_rdata (q2_rdata),
        .o_room  (q2_room)
    );

    assign o_out = t_line'(q2_rdata);

endmodule
